// ===== hdl/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types, constants and helpers for the ray/box slab test.
// ----------------------------------------------------------------------------
`default_nettype none

package rbst_pkg;

  localparam int WORD_W = 32;
  localparam int NUM_AXES = 3;
  localparam int NUM_LANES = 6;

  localparam logic [WORD_W-1:0] T_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] T_MIN = 32'h8000_0000;

  // per-lane divider sideband
  typedef struct packed {
    logic neg;  // quotient sign
    logic ovf;  // a quotient bit fell off the top
  } lane_ctl_t;

  // saturate an unsigned quotient magnitude and apply its sign
  function automatic logic [WORD_W-1:0] sat_q(input logic [WORD_W-1:0] q,
                                               input logic big,
                                               input logic neg);
    logic [WORD_W-1:0] r;
    if (neg) begin
      r = big ? T_MIN : (~q + 1'b1);
    end else begin
      r = big ? T_MAX : q;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray versus axis-aligned box slab test, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one request carries the ray origin, direction and the
//   box corners, twelve signed fixed-point words with FRAC_BITS fraction bits.
//   Output channel out_*: one result per request, hit flag and entry param.
//   A request may be offered every cycle; the pipeline takes one per cycle
//   while the output is not stalled. The stages are one setup stage,
//   FRAC_BITS + 33 divider cells (one quotient bit each, six lanes side by
//   side), one stage to saturate and order the slab bounds and the output
//   register that folds the interval.
//   All stages advance together; when the receiver holds out_tready low with
//   a result waiting, the whole pipe freezes and in_tready drops, so nothing
//   is lost or repeated.
//   Reset clears every valid bit; results in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_test
  import rbst_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  wire logic [383:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // hit [0], t_entry [32:1], zero pad [39:33]
  output logic [39:0]       out_tdata
);

  localparam int NUM_W = WORD_W + 1 + FRAC_BITS;

  logic en;
  assign en        = out_tready | ~out_tvalid;
  assign in_tready = en;

  // ---- setup ----
  logic [WORD_W-1:0] org  [NUM_AXES];
  logic [WORD_W-1:0] dir  [NUM_AXES];
  logic [WORD_W-1:0] bmin [NUM_AXES];
  logic [WORD_W-1:0] bmax [NUM_AXES];

  logic [WORD_W-1:0] den_s  [NUM_LANES];
  logic [NUM_W-1:0]  num_s  [NUM_LANES];
  lane_ctl_t         ctl_s  [NUM_LANES];
  logic [NUM_AXES-1:0] dz_s;
  logic                miss_s;

  always_comb begin
    logic signed [WORD_W:0] d;
    logic [NUM_W-1:0]       n;
    logic [WORD_W-1:0]      dm;
    miss_s = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      org[a]  = in_tdata[a*WORD_W +: WORD_W];
      dir[a]  = in_tdata[(3+a)*WORD_W +: WORD_W];
      bmin[a] = in_tdata[(6+a)*WORD_W +: WORD_W];
      bmax[a] = in_tdata[(9+a)*WORD_W +: WORD_W];
      dz_s[a] = (dir[a] == '0);
      if (dz_s[a] && (($signed(org[a]) < $signed(bmin[a])) ||
                      ($signed(org[a]) > $signed(bmax[a])))) begin
        miss_s = 1'b1;
      end
      dm = dir[a][WORD_W-1] ? (~dir[a] + 1'b1) : dir[a];
      for (int s = 0; s < 2; s++) begin
        d = (s == 0) ? ($signed({bmin[a][WORD_W-1], bmin[a]}) -
                        $signed({org[a][WORD_W-1], org[a]}))
                     : ($signed({bmax[a][WORD_W-1], bmax[a]}) -
                        $signed({org[a][WORD_W-1], org[a]}));
        n = {d, {FRAC_BITS{1'b0}}};
        num_s[2*a+s]     = d[WORD_W] ? (~n + 1'b1) : n;
        den_s[2*a+s]     = dm;
        ctl_s[2*a+s].neg = d[WORD_W] ^ dir[a][WORD_W-1];
        ctl_s[2*a+s].ovf = 1'b0;
      end
    end
  end

  // ---- divider chain ----
  logic [WORD_W-1:0] den_q [NUM_W+1][NUM_LANES];
  logic [WORD_W-1:0] rem_q [NUM_W+1][NUM_LANES];
  logic [NUM_W-1:0]  num_q [NUM_W+1][NUM_LANES];
  logic [WORD_W-1:0] quo_q [NUM_W+1][NUM_LANES];
  lane_ctl_t         ctl_q [NUM_W+1][NUM_LANES];
  logic [NUM_AXES-1:0] dz_r   [NUM_W+1];
  logic                miss_r [NUM_W+1];
  logic                vld_r  [NUM_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        den_q[0][l] <= den_s[l];
        rem_q[0][l] <= '0;
        num_q[0][l] <= num_s[l];
        quo_q[0][l] <= '0;
        ctl_q[0][l] <= ctl_s[l];
      end
      dz_r[0]   <= dz_s;
      miss_r[0] <= miss_s;
      for (int k = 0; k < NUM_W; k++) begin
        dz_r[k+1]   <= dz_r[k];
        miss_r[k+1] <= miss_r[k];
      end
    end
  end

  genvar gk, gl;
  generate
    for (gk = 0; gk < NUM_W; gk++) begin : g_step
      for (gl = 0; gl < NUM_LANES; gl++) begin : g_lane
        rbst_div_cell #(.NUM_W(NUM_W)) u_cell (
          .clk   (clk),
          .en    (en),
          .den_i (den_q[gk][gl]),
          .rem_i (rem_q[gk][gl]),
          .num_i (num_q[gk][gl]),
          .quo_i (quo_q[gk][gl]),
          .ctl_i (ctl_q[gk][gl]),
          .den_o (den_q[gk+1][gl]),
          .rem_o (rem_q[gk+1][gl]),
          .num_o (num_q[gk+1][gl]),
          .quo_o (quo_q[gk+1][gl]),
          .ctl_o (ctl_q[gk+1][gl])
        );
      end
    end
  endgenerate

  // ---- saturate and order ----
  logic [WORD_W-1:0] lo_nxt [NUM_AXES];
  logic [WORD_W-1:0] hi_nxt [NUM_AXES];
  logic [WORD_W-1:0] lo_r   [NUM_AXES];
  logic [WORD_W-1:0] hi_r   [NUM_AXES];
  logic              s1_miss_r;
  logic              s1_vld_r;

  always_comb begin
    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;
    for (int a = 0; a < NUM_AXES; a++) begin
      t1 = sat_q(quo_q[NUM_W][2*a], ctl_q[NUM_W][2*a].ovf | quo_q[NUM_W][2*a][WORD_W-1],
                 ctl_q[NUM_W][2*a].neg);
      t2 = sat_q(quo_q[NUM_W][2*a+1],
                 ctl_q[NUM_W][2*a+1].ovf | quo_q[NUM_W][2*a+1][WORD_W-1],
                 ctl_q[NUM_W][2*a+1].neg);
      if (dz_r[NUM_W][a]) begin
        // flat axis does not narrow the interval
        lo_nxt[a] = T_MIN;
        hi_nxt[a] = T_MAX;
      end else if ($signed(t1) > $signed(t2)) begin
        lo_nxt[a] = t2;
        hi_nxt[a] = t1;
      end else begin
        lo_nxt[a] = t1;
        hi_nxt[a] = t2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        lo_r[a] <= lo_nxt[a];
        hi_r[a] <= hi_nxt[a];
      end
      s1_miss_r <= miss_r[NUM_W];
    end
  end

  // ---- fold interval ----
  logic [WORD_W-1:0] tlo;
  logic [WORD_W-1:0] thi;
  logic              hit_nxt;
  logic              hit_r;
  logic [WORD_W-1:0] t_r;
  logic              out_vld_r;

  always_comb begin
    tlo = lo_r[0];
    thi = hi_r[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if ($signed(lo_r[a]) > $signed(tlo)) tlo = lo_r[a];
      if ($signed(hi_r[a]) < $signed(thi)) thi = hi_r[a];
    end
    hit_nxt = ~s1_miss_r && ($signed(tlo) <= $signed(thi)) && ~tlo[WORD_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
      t_r   <= hit_nxt ? tlo : '0;
    end
  end

  // ---- valid chain ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NUM_W; k++) vld_r[k] <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 0; k < NUM_W; k++) vld_r[k+1] <= vld_r[k];
      s1_vld_r  <= vld_r[NUM_W];
      out_vld_r <= s1_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, t_r, hit_r};

endmodule

`default_nettype wire

// ===== hdl/rbst_div_cell.sv =====
// ----------------------------------------------------------------------------
// rbst_div_cell
// One restoring-division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_div_cell
  import rbst_pkg::*;
#(
  parameter int NUM_W = 49
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [WORD_W-1:0] den_i,
  input  wire logic [WORD_W-1:0] rem_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [WORD_W-1:0] quo_i,
  input  wire lane_ctl_t         ctl_i,
  output logic      [WORD_W-1:0] den_o,
  output logic      [WORD_W-1:0] rem_o,
  output logic      [NUM_W-1:0]  num_o,
  output logic      [WORD_W-1:0] quo_o,
  output lane_ctl_t              ctl_o
);

  logic [WORD_W:0]   sh;
  logic [WORD_W:0]   diff;
  logic              ge;
  logic [WORD_W-1:0] rem_nxt;
  lane_ctl_t         ctl_nxt;

  always_comb begin
    sh      = {rem_i, num_i[NUM_W-1]};
    diff    = sh - {1'b0, den_i};
    ge      = (sh >= {1'b0, den_i});
    rem_nxt = ge ? diff[WORD_W-1:0] : sh[WORD_W-1:0];
    ctl_nxt.neg = ctl_i.neg;
    ctl_nxt.ovf = ctl_i.ovf | quo_i[WORD_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_o <= den_i;
      rem_o <= rem_nxt;
      num_o <= {num_i[NUM_W-2:0], 1'b0};
      quo_o <= {quo_i[WORD_W-2:0], ge};
      ctl_o <= ctl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rbst_checker.sv =====
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks for the ray/box slab test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a miss reports a zero entry parameter
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == 32'd0)
    else $error("miss with nonzero entry");

  // a hit never reports a negative entry
  a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[32])
    else $error("hit with negative entry");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/tb_ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// tb_ray_box_slab_test
// Self-checking bench for the ray/box slab test: a directed table, then
// random rays (mostly aimed at small boxes), all checked in order against
// a local slab-test predictor with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ray_box_slab_test;
  import rbst_pkg::*;

  localparam int FRAC = 16;
  localparam int LAT = FRAC + 36;
  localparam int N_RAND = 500;
  localparam int LIMIT = 400000;

  typedef logic [NUM_AXES*4-1:0][WORD_W-1:0] ray_box_t;

  typedef struct {
    ray_box_t rb;
    bit known;
    bit hit;
    logic [31:0] t;
  } row_t;

  typedef struct {
    bit hit;
    logic [31:0] t;
  } hit_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [383:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;

  hit_t pending_hits[$];
  int errors = 0;
  int cycles = 0;
  int accepted = 0;
  int rx_gap = 0;
  bit burst = 0;  // no idling on either side while set
  bit hold = 0;
  bit held_once = 0;

  always #5 clk = ~clk;

  ray_box_slab_test #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic longint slab_t(longint bound, longint org, longint dir);
    longint q;
    q = ((bound - org) * (longint'(1) << FRAC)) / dir;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic hit_t slab_hit(ray_box_t rb);
    longint lo, hi, o, d, bmn, bmx, t1, t2, tmp;
    bit ok;
    hit_t r;
    lo = -64'sd2147483648;
    hi = 64'sd2147483647;
    ok = 1;
    for (int a = 0; a < 3; a++) begin
      o = longint'($signed(rb[a]));
      d = longint'($signed(rb[3+a]));
      bmn = longint'($signed(rb[6+a]));
      bmx = longint'($signed(rb[9+a]));
      if (d == 0) begin
        if (o < bmn || o > bmx) ok = 0;
      end else begin
        t1 = slab_t(bmn, o, d);
        t2 = slab_t(bmx, o, d);
        if (t1 > t2) begin
          tmp = t1; t1 = t2; t2 = tmp;
        end
        if (t1 > lo) lo = t1;
        if (t2 < hi) hi = t2;
      end
    end
    if (lo > hi || lo < 0) ok = 0;
    r.hit = ok;
    r.t = ok ? lo[31:0] : 32'h0;
    return r;
  endfunction

  function automatic logic [31:0] fx(int v);
    return v <<< FRAC;
  endfunction

  function automatic ray_box_t mk(logic [31:0] ox, oy, oz, dx, dy, dz,
                                  nx, ny, nz, mx, my, mz);
    ray_box_t rb;
    rb[0] = ox; rb[1] = oy; rb[2] = oz; rb[3] = dx; rb[4] = dy; rb[5] = dz;
    rb[6] = nx; rb[7] = ny; rb[8] = nz; rb[9] = mx; rb[10] = my; rb[11] = mz;
    return rb;
  endfunction

  // mostly rays aimed at small boxes, some with flat axes, some pure noise
  function automatic ray_box_t rand_ray();
    ray_box_t rb;
    int kind, c, s, o;
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      for (int k = 0; k < 12; k++) rb[k] = $urandom;
      if (kind == 9) rb[3 + $urandom_range(0, 2)] = '0;
      return rb;
    end
    for (int a = 0; a < 3; a++) begin
      c = $urandom_range(0, 2000 << FRAC) - (1000 << FRAC);
      s = $urandom_range(1, 50 << FRAC);
      o = $urandom_range(0, 2000 << FRAC) - (1000 << FRAC);
      rb[6+a] = c - s;
      rb[9+a] = c + s;
      rb[a] = o;
      rb[3+a] = (c - o) >>> $urandom_range(0, 12);
      if (kind >= 6 && $urandom_range(0, 2) == 0) rb[3+a] = '0;
      if (kind == 5 && $urandom_range(0, 3) == 0) begin
        rb[6+a] = c + s;  // inverted slab
        rb[9+a] = c - s;
      end
    end
    return rb;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] exp_v);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, exp_v);
  endtask

  // one request at a time; valid held across back-to-back requests
  task automatic send(ray_box_t rb);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= rb;
    do @(posedge clk); while (!in_tready);
    pending_hits.push_back(slab_hit(rb));
    accepted++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // long receiver hold-off so the pipe fills and back-pressures the input
  always @(posedge clk) begin
    if (!held_once && accepted == 150) begin
      held_once <= 1;
      hold <= 1;
      repeat (400) @(posedge clk);
      hold <= 0;
    end
  end

  always @(posedge clk) begin
    hit_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_hits.size() == 0) begin
          report("unexpected result", out_tdata[31:0], '0);
        end else begin
          e = pending_hits.pop_front();
          if (out_tdata[0] !== e.hit) report("hit", out_tdata[0], e.hit);
          if (out_tdata[32:1] !== e.t) report("t_entry", out_tdata[32:1], e.t);
          if (out_tdata[39:33] !== '0) report("pad", out_tdata[39:33], '0);
        end
      end
      // receiver idles in random gaps, mostly short, a few long
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !hold;
        rx_gap <= pick_gap();
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    hit_t p;
    // all zero: flat on every axis, entry stays unbounded -> miss
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0});
    // flat axes, origin outside x slab
    rows.push_back('{mk(fx(5), 0, 0, 0, 0, 0, 0, 0, 0, fx(1), fx(1), fx(1)), 1, 0, 0});
    // origin inside box: negative entry
    rows.push_back('{mk(fx(1), fx(1), fx(1), fx(1), fx(1), fx(1),
                        0, 0, 0, fx(2), fx(2), fx(2)), 1, 0, 0});
    // straight hit along +x at t = 10
    rows.push_back('{mk(fx(-10), 32'h8000, 32'h8000, fx(1), 0, 0,
                        0, 0, 0, fx(1), fx(1), fx(1)), 1, 1, fx(10)});
    // negative direction, bounds swap, t = 9
    rows.push_back('{mk(fx(10), 32'h8000, 32'h8000, fx(-1), 0, 0,
                        0, 0, 0, fx(1), fx(1), fx(1)), 1, 1, fx(9)});
    // inverted box on a flat axis always misses
    rows.push_back('{mk(fx(-10), 0, 0, fx(1), 0, 0,
                        0, fx(1), 0, fx(1), fx(-1), fx(1)), 1, 0, 0});
    // extremes: saturation and limit words
    rows.push_back('{mk(T_MIN, T_MIN, T_MIN, 1, 1, 1,
                        T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX), 0, 0, 0});
    rows.push_back('{mk(T_MAX, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN,
                        T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN), 0, 0, 0});
    rows.push_back('{mk(T_MIN, T_MAX, 0, 1, -1, 32'hFFFF_FFFF,
                        T_MAX, T_MIN, T_MIN, T_MAX, T_MIN, T_MAX), 0, 0, 0});
    rows.push_back('{mk(0, 0, 0, T_MAX, T_MAX, T_MAX,
                        T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX), 0, 0, 0});
    rows.push_back('{mk(fx(-3), fx(-3), fx(-3), fx(1), fx(1), fx(1),
                        fx(-1), fx(-1), fx(-1), fx(1), fx(1), fx(1)), 0, 0, 0});
    rows.push_back('{mk(fx(-3), 0, fx(-3), fx(1), fx(7), fx(1),
                        fx(1), fx(-1), fx(-1), fx(-1), fx(1), fx(1)), 0, 0, 0});
    rows.push_back('{mk(T_MIN, 0, 0, T_MAX, 0, 0,
                        T_MAX, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX), 0, 0, 0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.known) begin
        p = slab_hit(r.rb);
        if (p.hit !== r.hit || p.t !== r.t) report("table row", p.t, r.t);
      end
      send(r.rb);
    end
    for (int i = 0; i < N_RAND; i++) begin
      burst = ((i / 64) % 4) == 1;
      send(rand_ray());
    end
    in_tvalid <= 1'b0;
    burst = 0;

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
